// File: sv/crf_pkg.sv
// Types and constants shared by the MOVEC control register file.
// Used by crf_regs and control_register_file_movec_unit; no dependencies.
package crf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CodeW = 12;
  localparam int unsigned RootW = 23;
  localparam int unsigned RootShift = 9;
  localparam int unsigned TtCount = 4;

  // Control register codes
  localparam logic [CodeW-1:0] CODE_SFC   = 12'h000;
  localparam logic [CodeW-1:0] CODE_DFC   = 12'h001;
  localparam logic [CodeW-1:0] CODE_CACR  = 12'h002;
  localparam logic [CodeW-1:0] CODE_TC    = 12'h003;
  localparam logic [CodeW-1:0] CODE_ITT0  = 12'h004;
  localparam logic [CodeW-1:0] CODE_ITT1  = 12'h005;
  localparam logic [CodeW-1:0] CODE_DTT0  = 12'h006;
  localparam logic [CodeW-1:0] CODE_DTT1  = 12'h007;
  localparam logic [CodeW-1:0] CODE_USP   = 12'h800;
  localparam logic [CodeW-1:0] CODE_VBR   = 12'h801;
  localparam logic [CodeW-1:0] CODE_MSP   = 12'h803;
  localparam logic [CodeW-1:0] CODE_ISP   = 12'h804;
  localparam logic [CodeW-1:0] CODE_MMUSR = 12'h805;
  localparam logic [CodeW-1:0] CODE_URP   = 12'h806;
  localparam logic [CodeW-1:0] CODE_SRP   = 12'h807;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_PRIV    = 2'd1,
    STATUS_ILLEGAL = 2'd2
  } status_t;

  typedef struct packed {
    logic             mode;
    logic [CodeW-1:0] ctrl_code;
    logic [DataW-1:0] write_value;
    logic             supervisor;
    logic             master;
    logic [DataW-1:0] current_a7;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [DataW-1:0] read_value;
    logic             a7_write;
    logic [DataW-1:0] new_a7;
    logic             flush_translation;
  } out_t;

endpackage

// File: sv/control_register_file_movec_unit.sv
// MOVEC control register file: one access per beat.
// Each access passes through an input register and a result register on its way to the result beat.
// Throughput: one access per cycle while the result side keeps taking beats;
// the access decode and register update sit in the logic between the two registers.
// Reset (rst, synchronous): all control registers clear to zero, both stages empty.
// Depends on crf_pkg and crf_regs.
module control_register_file_movec_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  crf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output crf_pkg::out_t out_data
);
  import crf_pkg::*;

  logic  stage_valid;
  in_t   stage_item;
  logic  advance;
  out_t  result;

  // Move the staged access into the result register when that slot frees up
  assign advance  = stage_valid & (~out_valid | out_ready);
  assign in_ready = ~stage_valid | advance;

  crf_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (stage_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// File: sv/crf_regs.sv
// Control register storage with access decode, write masking and A7 aliasing.
// Depends on crf_pkg.
module crf_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          commit,
  input  crf_pkg::in_t  item,
  output crf_pkg::out_t result
);
  import crf_pkg::*;

  logic [2:0]       source_fc, source_fc_next;
  logic [2:0]       dest_fc, dest_fc_next;
  logic [1:0]       cache_control, cache_control_next;
  logic [1:0]       translation_control, translation_control_next;
  logic [DataW-1:0] transparent_windows [TtCount];
  logic [DataW-1:0] transparent_windows_next [TtCount];
  logic [DataW-1:0] user_sp, user_sp_next;
  logic [DataW-1:0] vector_base, vector_base_next;
  logic [DataW-1:0] master_sp, master_sp_next;
  logic [DataW-1:0] interrupt_sp, interrupt_sp_next;
  logic [DataW-1:0] mmu_status, mmu_status_next;
  logic [RootW-1:0] user_root, user_root_next;
  logic [RootW-1:0] supervisor_root, supervisor_root_next;

  logic             wr;
  logic             msp_live;
  logic             isp_live;
  logic [1:0]       tt_sel;
  logic [DataW-1:0] v;

  assign wr       = (item.mode == MODE_WRITE);
  assign msp_live = item.supervisor & item.master;
  assign isp_live = item.supervisor & ~item.master;
  assign tt_sel   = item.ctrl_code[1:0];
  assign v        = item.write_value;

  always_comb begin
    source_fc_next           = source_fc;
    dest_fc_next             = dest_fc;
    cache_control_next       = cache_control;
    translation_control_next = translation_control;
    transparent_windows_next = transparent_windows;
    user_sp_next             = user_sp;
    vector_base_next         = vector_base;
    master_sp_next           = master_sp;
    interrupt_sp_next        = interrupt_sp;
    mmu_status_next          = mmu_status;
    user_root_next           = user_root;
    supervisor_root_next     = supervisor_root;

    result                   = '0;
    result.status            = STATUS_DONE;

    if (!item.supervisor) begin
      result.status = STATUS_PRIV;
    end else begin
      unique case (item.ctrl_code)
        CODE_SFC: begin
          if (wr) source_fc_next = v[2:0];
          else    result.read_value = {{(DataW-3){1'b0}}, source_fc};
        end
        CODE_DFC: begin
          if (wr) dest_fc_next = v[2:0];
          else    result.read_value = {{(DataW-3){1'b0}}, dest_fc};
        end
        CODE_CACR: begin
          // Only the data and instruction cache enables are kept
          if (wr) begin
            cache_control_next = {v[31], v[15]};
          end else begin
            result.read_value     = '0;
            result.read_value[31] = cache_control[1];
            result.read_value[15] = cache_control[0];
          end
        end
        CODE_TC: begin
          if (wr) begin
            translation_control_next = v[15:14];
            result.flush_translation = 1'b1;
          end else begin
            result.read_value        = '0;
            result.read_value[15:14] = translation_control;
          end
        end
        CODE_ITT0, CODE_ITT1, CODE_DTT0, CODE_DTT1: begin
          if (wr) transparent_windows_next[tt_sel] = v;
          else    result.read_value = transparent_windows[tt_sel];
        end
        CODE_USP: begin
          if (wr) user_sp_next = v;
          else    result.read_value = user_sp;
        end
        CODE_VBR: begin
          if (wr) vector_base_next = v;
          else    result.read_value = vector_base;
        end
        CODE_MSP: begin
          // Active stack pointer lives in A7
          if (wr) begin
            if (msp_live) begin
              result.a7_write = 1'b1;
              result.new_a7   = v;
            end else begin
              master_sp_next = v;
            end
          end else begin
            result.read_value = msp_live ? item.current_a7 : master_sp;
          end
        end
        CODE_ISP: begin
          if (wr) begin
            if (isp_live) begin
              result.a7_write = 1'b1;
              result.new_a7   = v;
            end else begin
              interrupt_sp_next = v;
            end
          end else begin
            result.read_value = isp_live ? item.current_a7 : interrupt_sp;
          end
        end
        CODE_MMUSR: begin
          if (wr) mmu_status_next = v;
          else    result.read_value = mmu_status;
        end
        CODE_URP: begin
          if (wr) begin
            user_root_next           = v[DataW-1:RootShift];
            result.flush_translation = 1'b1;
          end else begin
            result.read_value = {user_root, {RootShift{1'b0}}};
          end
        end
        CODE_SRP: begin
          if (wr) begin
            supervisor_root_next     = v[DataW-1:RootShift];
            result.flush_translation = 1'b1;
          end else begin
            result.read_value = {supervisor_root, {RootShift{1'b0}}};
          end
        end
        default: begin
          result.status = STATUS_ILLEGAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_fc           <= '0;
      dest_fc             <= '0;
      cache_control       <= '0;
      translation_control <= '0;
      for (int i = 0; i < TtCount; i++) transparent_windows[i] <= '0;
      user_sp             <= '0;
      vector_base         <= '0;
      master_sp           <= '0;
      interrupt_sp        <= '0;
      mmu_status          <= '0;
      user_root           <= '0;
      supervisor_root     <= '0;
    end else if (commit) begin
      source_fc           <= source_fc_next;
      dest_fc             <= dest_fc_next;
      cache_control       <= cache_control_next;
      translation_control <= translation_control_next;
      transparent_windows <= transparent_windows_next;
      user_sp             <= user_sp_next;
      vector_base         <= vector_base_next;
      master_sp           <= master_sp_next;
      interrupt_sp        <= interrupt_sp_next;
      mmu_status          <= mmu_status_next;
      user_root           <= user_root_next;
      supervisor_root     <= supervisor_root_next;
    end
  end

endmodule

// File: verif/control_register_file_movec_unit_test.sv
// Self-checking testbench for the MOVEC control register file.
// Drives accesses over the valid/ready channels and checks every result beat.
// Depends on crf_pkg and control_register_file_movec_unit.
module control_register_file_movec_unit_test;
  import crf_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PrintLimit = 40;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  control_register_file_movec_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Shadow copy of the control registers
  logic [2:0] src_fc;
  logic [2:0] dst_fc;
  logic [1:0] cache_bits;
  logic [1:0] xlate_bits;
  logic [DataW-1:0] tt_window [TtCount];
  logic [DataW-1:0] usp_copy;
  logic [DataW-1:0] vbr_copy;
  logic [DataW-1:0] msp_copy;
  logic [DataW-1:0] isp_copy;
  logic [DataW-1:0] mmusr_copy;
  logic [RootW-1:0] user_root_ptr;
  logic [RootW-1:0] sup_root_ptr;

  logic [CodeW-1:0] reg_codes [15];
  out_t pending_results [$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  always #10 clk = ~clk;

  // Apply one access to the shadow registers and return the result it should give.
  function automatic out_t movec_access(input in_t acc);
    out_t res;
    logic msp_live;
    logic isp_live;
    res = '0;
    msp_live = acc.supervisor && acc.master;
    isp_live = acc.supervisor && !acc.master;
    if (!acc.supervisor) begin
      res.status = STATUS_PRIV;
    end else if (acc.mode == MODE_WRITE) begin
      case (acc.ctrl_code)
        CODE_SFC: src_fc = acc.write_value[2:0];
        CODE_DFC: dst_fc = acc.write_value[2:0];
        CODE_CACR: cache_bits = {acc.write_value[31], acc.write_value[15]};
        CODE_TC: begin
          xlate_bits = acc.write_value[15:14];
          res.flush_translation = 1'b1;
        end
        CODE_ITT0, CODE_ITT1, CODE_DTT0, CODE_DTT1:
          tt_window[acc.ctrl_code[1:0]] = acc.write_value;
        CODE_USP: usp_copy = acc.write_value;
        CODE_VBR: vbr_copy = acc.write_value;
        CODE_MSP: begin
          if (msp_live) begin
            res.a7_write = 1'b1;
            res.new_a7 = acc.write_value;
          end else begin
            msp_copy = acc.write_value;
          end
        end
        CODE_ISP: begin
          if (isp_live) begin
            res.a7_write = 1'b1;
            res.new_a7 = acc.write_value;
          end else begin
            isp_copy = acc.write_value;
          end
        end
        CODE_MMUSR: mmusr_copy = acc.write_value;
        CODE_URP: begin
          user_root_ptr = acc.write_value[31:9];
          res.flush_translation = 1'b1;
        end
        CODE_SRP: begin
          sup_root_ptr = acc.write_value[31:9];
          res.flush_translation = 1'b1;
        end
        default: res.status = STATUS_ILLEGAL;
      endcase
    end else begin
      case (acc.ctrl_code)
        CODE_SFC: res.read_value = {29'd0, src_fc};
        CODE_DFC: res.read_value = {29'd0, dst_fc};
        CODE_CACR: res.read_value = {cache_bits[1], 15'd0, cache_bits[0], 15'd0};
        CODE_TC: res.read_value = {16'd0, xlate_bits, 14'd0};
        CODE_ITT0, CODE_ITT1, CODE_DTT0, CODE_DTT1:
          res.read_value = tt_window[acc.ctrl_code[1:0]];
        CODE_USP: res.read_value = usp_copy;
        CODE_VBR: res.read_value = vbr_copy;
        CODE_MSP: res.read_value = msp_live ? acc.current_a7 : msp_copy;
        CODE_ISP: res.read_value = isp_live ? acc.current_a7 : isp_copy;
        CODE_MMUSR: res.read_value = mmusr_copy;
        CODE_URP: res.read_value = {user_root_ptr, 9'd0};
        CODE_SRP: res.read_value = {sup_root_ptr, 9'd0};
        default: res.status = STATUS_ILLEGAL;
      endcase
    end
    return res;
  endfunction

  function automatic in_t make_access(input logic mode, input logic [CodeW-1:0] code,
                                      input logic [DataW-1:0] value, input logic sup,
                                      input logic mst, input logic [DataW-1:0] a7);
    in_t acc;
    acc.mode = mode;
    acc.ctrl_code = code;
    acc.write_value = value;
    acc.supervisor = sup;
    acc.master = mst;
    acc.current_a7 = a7;
    return acc;
  endfunction

  function automatic in_t random_access();
    in_t acc;
    int pick;
    pick = $urandom_range(0, 99);
    acc.mode = 1'($urandom_range(0, 1));
    if (pick < 85) begin
      acc.ctrl_code = reg_codes[$urandom_range(0, 14)];
    end else begin
      acc.ctrl_code = CodeW'($urandom_range(0, 4095));
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      acc.write_value = '0;
    end else if (pick == 1) begin
      acc.write_value = '1;
    end else begin
      acc.write_value = $urandom();
    end
    acc.supervisor = ($urandom_range(0, 99) < 90);
    acc.master = 1'($urandom_range(0, 1));
    acc.current_a7 = $urandom();
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    if (error_count < PrintLimit) begin
      $display("mismatch %0s: got %h, want %h at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_access(input in_t acc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(movec_access(acc));
    @(negedge clk);
  endtask

  // Hold off the sender until every expected beat is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_privilege_and_illegal();
    send_access(make_access(MODE_WRITE, CODE_SFC, '1, 1'b0, 1'b0, '1));
    send_access(make_access(MODE_READ, 12'hFFF, '0, 1'b0, 1'b1, '0));
    send_access(make_access(MODE_WRITE, 12'h802, '1, 1'b1, 1'b0, '1));
    send_access(make_access(MODE_READ, 12'hFFF, '1, 1'b1, 1'b1, '1));
  endtask

  task automatic test_write_masks();
    send_access(make_access(MODE_WRITE, CODE_SFC, '1, 1'b1, 1'b0, '0));
    send_access(make_access(MODE_WRITE, CODE_DFC, '1, 1'b1, 1'b1, '0));
    send_access(make_access(MODE_WRITE, CODE_CACR, '1, 1'b1, 1'b0, '0));
    send_access(make_access(MODE_WRITE, CODE_TC, '1, 1'b1, 1'b0, '0));
    send_access(make_access(MODE_WRITE, CODE_URP, '1, 1'b1, 1'b1, '0));
    send_access(make_access(MODE_WRITE, CODE_SRP, '1, 1'b1, 1'b0, '0));
    send_access(make_access(MODE_READ, CODE_SFC, '0, 1'b1, 1'b0, '1));
    send_access(make_access(MODE_READ, CODE_DFC, '0, 1'b1, 1'b1, '1));
    send_access(make_access(MODE_READ, CODE_CACR, '0, 1'b1, 1'b0, '1));
    send_access(make_access(MODE_READ, CODE_TC, '0, 1'b1, 1'b0, '1));
    send_access(make_access(MODE_READ, CODE_URP, '0, 1'b1, 1'b1, '1));
    send_access(make_access(MODE_READ, CODE_SRP, '0, 1'b1, 1'b0, '1));
  endtask

  task automatic test_stack_alias();
    send_access(make_access(MODE_WRITE, CODE_MSP, 32'h1111_0000, 1'b1, 1'b1, 32'hA0));
    send_access(make_access(MODE_WRITE, CODE_ISP, 32'h2222_0000, 1'b1, 1'b0, 32'hA1));
    send_access(make_access(MODE_WRITE, CODE_MSP, 32'h3333_0000, 1'b1, 1'b0, 32'hA2));
    send_access(make_access(MODE_WRITE, CODE_ISP, 32'h4444_0000, 1'b1, 1'b1, 32'hA3));
    send_access(make_access(MODE_READ, CODE_MSP, '0, 1'b1, 1'b0, 32'hA4));
    send_access(make_access(MODE_READ, CODE_MSP, '0, 1'b1, 1'b1, 32'hA5));
    send_access(make_access(MODE_READ, CODE_ISP, '0, 1'b1, 1'b1, 32'hA6));
    send_access(make_access(MODE_READ, CODE_ISP, '0, 1'b1, 1'b0, 32'hA7));
    // USP is never the live stack in supervisor state
    send_access(make_access(MODE_WRITE, CODE_USP, 32'h5555_0000, 1'b1, 1'b1, 32'hA8));
    send_access(make_access(MODE_READ, CODE_USP, '0, 1'b1, 1'b0, 32'hA9));
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    in_t acc;
    int sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      acc = random_access();
      send_access(acc);
      sent++;
      // Read back what was just written, often under the other stack selection
      if (acc.mode == MODE_WRITE && $urandom_range(0, 99) < 40) begin
        acc.mode = MODE_READ;
        acc.master = 1'($urandom_range(0, 1));
        acc.current_a7 = $urandom();
        send_access(acc);
        sent++;
      end
    end
    drain_results();
  endtask

  // Receiver: drop ready at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", out_data.read_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", DataW'(out_data.status), DataW'(want.status));
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.a7_write !== want.a7_write)
          report_mismatch("a7_write", DataW'(out_data.a7_write), DataW'(want.a7_write));
        if (out_data.new_a7 !== want.new_a7)
          report_mismatch("new_a7", out_data.new_a7, want.new_a7);
        if (out_data.flush_translation !== want.flush_translation)
          report_mismatch("flush_translation", DataW'(out_data.flush_translation),
                          DataW'(want.flush_translation));
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    src_fc = '0;
    dst_fc = '0;
    cache_bits = '0;
    xlate_bits = '0;
    for (int i = 0; i < TtCount; i++) tt_window[i] = '0;
    usp_copy = '0;
    vbr_copy = '0;
    msp_copy = '0;
    isp_copy = '0;
    mmusr_copy = '0;
    user_root_ptr = '0;
    sup_root_ptr = '0;
    reg_codes = '{CODE_SFC, CODE_DFC, CODE_CACR, CODE_TC, CODE_ITT0, CODE_ITT1, CODE_DTT0,
                  CODE_DTT1, CODE_USP, CODE_VBR, CODE_MSP, CODE_ISP, CODE_MMUSR, CODE_URP,
                  CODE_SRP};

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_privilege_and_illegal();
    test_write_masks();
    test_stack_alias();
    drain_results();
    test_random_traffic(460, 30, 46);
    test_random_traffic(460, 46, 30);
    test_random_traffic(460, 0, 0);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
